FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL, clocked on the rising edge with an
// active-low reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pwmm_pkg.sv
// ----------------------------------------------------------------------------
// pwmm_pkg
// Shared constants and controller/datapath interface types for the PWM meter.
// ----------------------------------------------------------------------------
package pwmm_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int DUTY_W = 7;
	localparam int FREQ_W = 32;
	localparam int FIELD_W = 16;
	localparam int CLK_HZ_W = 32;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
	localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 32'd16000000;

	typedef struct packed {
		logic tick;
		logic start_duty;
		logic start_freq;
		logic take_duty;
		logic take_freq;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic rise;
		logic zero;
		logic div_done;
	} status_t;

endpackage

FILE: src/pwmm_div.sv
// ----------------------------------------------------------------------------
// pwmm_div
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module pwmm_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

FILE: src/pwmm_dp.sv
// ----------------------------------------------------------------------------
// pwmm_dp
// Datapath: tick counter, edge capture, clock register, divider operands and
// the output register.
// ----------------------------------------------------------------------------
module pwmm_dp #(
	parameter int COUNTER_BITS = pwmm_pkg::COUNTER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pwmm_pkg::cmd_t                    cmd,
	output pwmm_pkg::status_t                 status,
	input  logic                              pwm_level,
	input  logic                              cfg_we,
	input  logic [pwmm_pkg::CLK_HZ_W-1:0]     cfg_data,
	output logic [pwmm_pkg::DUTY_W-1:0]       duty_percent,
	output logic [pwmm_pkg::FREQ_W-1:0]       frequency,
	output logic [pwmm_pkg::FIELD_W-1:0]      period_ticks,
	output logic [pwmm_pkg::FIELD_W-1:0]      high_ticks,
	output logic                              zero_period
);

	localparam int PROD_W = COUNTER_BITS + pwmm_pkg::DUTY_W;
	localparam int NUM_W  = (PROD_W > pwmm_pkg::CLK_HZ_W) ? PROD_W : pwmm_pkg::CLK_HZ_W;

	logic [COUNTER_BITS-1:0]          cnt_q;
	logic [COUNTER_BITS-1:0]          cnt_inc;
	logic [COUNTER_BITS-1:0]          period_q;
	logic [COUNTER_BITS-1:0]          high_q;
	logic                             prev_q;
	logic [pwmm_pkg::CLK_HZ_W-1:0]    clock_hz_q;
	logic [pwmm_pkg::DUTY_W-1:0]      duty_q;
	logic [pwmm_pkg::FREQ_W-1:0]      freq_q;
	logic [PROD_W-1:0]                prod;
	logic [NUM_W-1:0]                 div_num;
	logic [NUM_W-1:0]                 quot;
	logic                             div_done;
	logic [pwmm_pkg::DUTY_W-1:0]      duty_sat;
	logic                             zero;

	assign cnt_inc = cnt_q + 1'b1;
	assign zero    = period_q == '0;
	assign prod    = PROD_W'(high_q) * PROD_W'(pwmm_pkg::DUTY_FULL);
	assign div_num = cmd.start_duty ? NUM_W'(prod) : NUM_W'(clock_hz_q);
	assign duty_sat = (quot > NUM_W'(pwmm_pkg::DUTY_FULL)) ? pwmm_pkg::DUTY_FULL
		: quot[pwmm_pkg::DUTY_W-1:0];

	assign status.rise     = !prev_q && pwm_level;
	assign status.zero     = zero;
	assign status.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			prev_q     <= 1'b0;
			high_q     <= '0;
			clock_hz_q <= pwmm_pkg::CLK_HZ_RESET;
		end else begin
			if (cfg_we) begin
				clock_hz_q <= cfg_data;
			end
			if (cmd.tick) begin
				prev_q <= pwm_level;
				if (!prev_q && pwm_level) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_inc;
				end
				if (prev_q && !pwm_level) begin
					high_q <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick && !prev_q && pwm_level) begin
			period_q <= cnt_inc;
		end
		if (cmd.take_duty) begin
			duty_q <= duty_sat;
		end
		if (cmd.take_freq) begin
			freq_q <= quot[pwmm_pkg::FREQ_W-1:0];
		end
		if (cmd.load_out) begin
			duty_percent <= zero ? '0 : duty_q;
			frequency    <= zero ? '0 : freq_q;
			period_ticks <= pwmm_pkg::FIELD_W'(period_q);
			high_ticks   <= pwmm_pkg::FIELD_W'(high_q);
			zero_period  <= zero;
		end
	end

	pwmm_div #(
		.NUM_W(NUM_W),
		.DEN_W(COUNTER_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start_duty || cmd.start_freq),
		.num   (div_num),
		.den   (period_q),
		.done  (div_done),
		.quot  (quot)
	);

endmodule

FILE: src/pwmm_ctrl.sv
// ----------------------------------------------------------------------------
// pwmm_ctrl
// Controller: input handshake, division sequencing and output valid.
// ----------------------------------------------------------------------------
module pwmm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pwmm_pkg::status_t status,
	output pwmm_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DUTY,
		ST_FREQ,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.tick       = in_valid && in_ready;
		cmd.start_duty = state_q == ST_START && !status.zero;
		cmd.take_duty  = state_q == ST_DUTY && status.div_done;
		cmd.start_freq = cmd.take_duty;
		cmd.take_freq  = state_q == ST_FREQ && status.div_done;
		cmd.load_out   = state_q == ST_HOLD && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.tick && status.rise) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= status.zero ? ST_HOLD : ST_DUTY;
				end
				ST_DUTY: begin
					if (status.div_done) begin
						state_q <= ST_FREQ;
					end
				end
				ST_FREQ: begin
					if (status.div_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/pwm_input_duty_frequency_meter.sv
// ----------------------------------------------------------------------------
// pwm_input_duty_frequency_meter
// PWM input capture: high time, period, duty cycle in percent and frequency.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, pwm_level): one request per counter
//   tick. Ticks that are not a rising edge are taken one per cycle while
//   no earlier rising edge is in progress. A rising edge starts two
//   iterative divisions (duty, then frequency) on a shared radix-2 divider
//   of NW = max(32, COUNTER_BITS+7) bits; in_ready is low until the result
//   is in the output register. A zero period skips the divisions.
//   Output channel (out_valid/out_ready): one request per rising edge from a
//   registered output stage; ticks keep flowing while a result waits, but the
//   next rising edge holds in its final step until the receiver takes it.
//   Config channel (cfg_valid/cfg_ready, cfg_data): writes clock_hz, always
//   ready; write only while the block is idle.
//   Reset: counter, previous level and high capture clear, clock_hz returns
//   to 16000000, no result is pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwm_input_duty_frequency_meter #(
	parameter int COUNTER_BITS = pwmm_pkg::COUNTER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          pwm_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pwmm_pkg::DUTY_W-1:0]   duty_percent,
	output logic [pwmm_pkg::FREQ_W-1:0]   frequency,
	output logic [pwmm_pkg::FIELD_W-1:0]  period_ticks,
	output logic [pwmm_pkg::FIELD_W-1:0]  high_ticks,
	output logic                          zero_period,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwmm_pkg::CLK_HZ_W-1:0] cfg_data
);

	pwmm_pkg::cmd_t    cmd;
	pwmm_pkg::status_t status;

	assign cfg_ready = 1'b1;

	pwmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pwmm_dp #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.pwm_level   (pwm_level),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.duty_percent(duty_percent),
		.frequency   (frequency),
		.period_ticks(period_ticks),
		.high_ticks  (high_ticks),
		.zero_period (zero_period)
	);

	`ASSERT_CLK(a_zero_forces_zero, clk, arst_n, !out_valid || !zero_period || (duty_percent == '0 && frequency == '0), "zero period result has nonzero duty or frequency")
	`ASSERT_CLK(a_duty_saturated, clk, arst_n, !out_valid || duty_percent <= pwmm_pkg::DUTY_FULL, "duty above full scale")
	`ASSERT_NEXT(a_rise_blocks_input, clk, arst_n, cmd.tick && status.rise, !in_ready, "input still ready after rising edge")
	`ASSERT_CLK(a_load_only_when_free, clk, arst_n, !cmd.load_out || !out_valid || out_ready, "output overwritten while pending")

endmodule
